FILE: hw/rtl/lkpmc_pkg.sv
// Shared types and constants for the line k-partition min-cost unit.
package lkpmc_pkg;

    localparam int POS_W       = 20;
    localparam int WGT_W       = 20;
    localparam int CFG_W       = 11;
    localparam int COST_W      = 50;
    localparam int ROW_W       = 60;
    localparam int STACK_DEPTH = 64;
    localparam int SA_W        = $clog2(STACK_DEPTH);
    localparam int SP_W        = SA_W + 1;

    localparam logic [ROW_W-1:0] ROW_UNREACHED = {ROW_W{1'b1}};
    localparam logic [CFG_W-1:0] PART_COUNT_RST = CFG_W'(1);

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_ROWSTART,
        S_POP,
        S_FRAME,
        S_TAIL,
        S_TAILW,
        S_Q0,
        S_Q1,
        S_Q2,
        S_Q3,
        S_Q4,
        S_WRITE,
        S_PUSH1,
        S_PUSH2,
        S_NEXT,
        S_RES,
        S_RESW,
        S_DONE
    } t_state;

endpackage

FILE: hw/rtl/lkpmc_if.sv
// Point and result channel interfaces for the line k-partition min-cost unit.
interface lkpmc_pt_if;
    logic                        valid;
    logic                        ready;
    logic [lkpmc_pkg::POS_W-1:0] position;
    logic [lkpmc_pkg::WGT_W-1:0] weight;
    logic                        last_item;

    modport source (output valid, position, weight, last_item, input ready);
    modport sink   (input valid, position, weight, last_item, output ready);
endinterface

interface lkpmc_res_if;
    logic                         valid;
    logic                         ready;
    logic [lkpmc_pkg::COST_W-1:0] min_cost;
    logic                         feasible;
    logic                         order_error;

    modport source (output valid, min_cost, feasible, order_error, input ready);
    modport sink   (input valid, min_cost, feasible, order_error, output ready);
endinterface

FILE: hw/rtl/line_k_partition_min_cost_dp_unit.sv
// Top level: point loader and row-by-row split search for min-cost line partition.
//
//  channel   | dir | word                               | handshake
//  i_pt      | in  | position, weight, last_item        | valid/ready
//  o_res     | out | min_cost, feasible, order_error    | valid/ready
//  i_cfg_*   | in  | part_count                         | write enable
//
// Loading takes one word per cycle. After the last word the search runs
// k rows; each row visits O(n log n) candidate splits through states Q0 to Q4, plus
// pop/frame/tail/write/push/next per frame and a start state per row, all through one
// multiply/subtract/compare loop and single read ports on the point and row stores.
// Reset is synchronous active low; stores need no clearing.
// Intake stalls from the last word until the result is in the output register.
module line_k_partition_min_cost_dp_unit #(
    parameter int MAX_ITEMS = 1024,
    parameter int MAX_PARTS = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lkpmc_pkg::CFG_W-1:0] i_cfg_wdata,
    lkpmc_pt_if.sink                    i_pt,
    lkpmc_res_if.source                 o_res
);
    import lkpmc_pkg::*;

    localparam int IW  = $clog2(MAX_ITEMS + 1);
    localparam int AW  = $clog2(MAX_ITEMS);
    localparam int LW  = $clog2(MAX_ITEMS);
    localparam int WW  = WGT_W + LW;
    localparam int MW  = POS_W + WGT_W + LW;
    localparam int PTW = POS_W + WW + MW;
    localparam int FW  = 4 * IW;

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_k;
    logic [IW-1:0]    r_cnt;
    logic             r_fault;
    logic             r_feas;
    logic [WW-1:0]    r_pw;
    logic [MW-1:0]    r_pm;
    logic [POS_W-1:0] r_last_pos;

    logic [PTW-1:0]   pt_mem [MAX_ITEMS];
    logic [PTW-1:0]   r_pt_q;
    logic [AW-1:0]    pt_ra;

    logic [ROW_W-1:0] row_a [MAX_ITEMS+1];
    logic [ROW_W-1:0] row_b [MAX_ITEMS+1];
    logic [ROW_W-1:0] r_rowa_q, r_rowb_q;
    logic [IW-1:0]    row_ra;

    logic [FW-1:0]    stk_mem [STACK_DEPTH];
    logic [FW-1:0]    r_stk_q;
    logic             stk_we;
    logic [SA_W-1:0]  stk_wa;
    logic [FW-1:0]    stk_wd;
    logic [SP_W-1:0]  r_sp;
    logic [SP_W-1:0]  sp_m1;

    logic [CFG_W-1:0] r_p;
    logic             r_bank;
    logic [IW-1:0]    r_lo, r_hi, r_olo, r_ohi, r_mid, r_q, r_bo;
    logic [ROW_W-1:0] r_best, r_prev, r_res;
    logic [POS_W-1:0] r_tpos;
    logic [WW-1:0]    r_tpw, r_w;
    logic [MW-1:0]    r_tpm, r_m, r_prod, r_cost;

    logic             r_out_valid;
    logic [COST_W-1:0] r_out_cost;
    logic             r_out_feas, r_out_err;

    logic             accept;
    logic             load_ok;
    logic [WW-1:0]    n_pw;
    logic [MW-1:0]    n_pm;
    logic [IW-1:0]    p_iw, f_lo, f_hi, f_olo, f_ohi, f_mid;
    logic [POS_W-1:0] pt_pos;
    logic [WW-1:0]    pt_pw;
    logic [MW-1:0]    pt_pm;
    logic [ROW_W-1:0] prev_q;
    logic [ROW_W:0]   cand;
    logic             feas_now;
    logic             out_free;

    assign accept   = i_pt.valid && i_pt.ready;
    assign load_ok  = 32'(r_cnt) < MAX_ITEMS;
    assign n_pw     = r_pw + WW'(i_pt.weight);
    assign n_pm     = r_pm + MW'(i_pt.position * i_pt.weight);
    assign p_iw     = IW'(r_p);
    assign sp_m1    = r_sp - SP_W'(1);
    assign f_lo     = r_stk_q[FW-1 -: IW];
    assign f_hi     = r_stk_q[3*IW-1 -: IW];
    assign f_olo    = r_stk_q[2*IW-1 -: IW];
    assign f_ohi    = r_stk_q[IW-1:0];
    assign f_mid    = f_lo + ((f_hi - f_lo) >> 1);
    assign pt_pos   = r_pt_q[PTW-1 -: POS_W];
    assign pt_pw    = r_pt_q[MW +: WW];
    assign pt_pm    = r_pt_q[MW-1:0];
    assign prev_q   = r_bank ? r_rowa_q : r_rowb_q;
    assign cand     = {1'b0, r_prev} + (ROW_W+1)'(r_cost);
    assign feas_now = (r_k != '0) && (32'(r_k) <= 32'(r_cnt)) && (32'(r_k) <= MAX_PARTS);
    assign out_free = !r_out_valid || o_res.ready;

    assign i_pt.ready        = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.min_cost    = r_out_cost;
    assign o_res.feasible    = r_out_feas;
    assign o_res.order_error = r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        pt_ra   = '0;
        row_ra  = '0;
        stk_we  = 1'b0;
        stk_wa  = r_sp[SA_W-1:0];
        stk_wd  = '0;
        case (r_state)
            S_IDLE: begin
                if (accept && i_pt.last_item) n_state = S_START;
            end
            S_START: begin
                n_state = (feas_now && !r_fault) ? S_ROWSTART : S_DONE;
            end
            S_ROWSTART: begin
                stk_we  = 1'b1;
                stk_wa  = '0;
                stk_wd  = {p_iw, r_cnt, p_iw - IW'(1), r_cnt - IW'(1)};
                n_state = S_POP;
            end
            S_POP:   n_state = S_FRAME;
            S_FRAME: n_state = S_TAIL;
            S_TAIL: begin
                pt_ra   = AW'(r_mid - IW'(1));
                n_state = S_TAILW;
            end
            S_TAILW: n_state = S_Q0;
            S_Q0: begin
                if (r_q <= r_ohi && r_q < r_mid) begin
                    pt_ra   = AW'(r_q - IW'(1));
                    row_ra  = r_q;
                    n_state = S_Q1;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_Q1:    n_state = S_Q2;
            S_Q2:    n_state = S_Q3;
            S_Q3:    n_state = S_Q4;
            S_Q4:    n_state = S_Q0;
            S_WRITE: n_state = S_PUSH1;
            S_PUSH1: begin
                if (r_mid < r_hi && 32'(r_sp) < STACK_DEPTH) begin
                    stk_we = 1'b1;
                    stk_wd = {r_mid + IW'(1), r_hi, r_bo, r_ohi};
                end
                n_state = S_PUSH2;
            end
            S_PUSH2: begin
                if (r_mid > r_lo && 32'(r_sp) < STACK_DEPTH) begin
                    stk_we = 1'b1;
                    stk_wd = {r_lo, r_mid - IW'(1), r_olo, r_bo};
                end
                n_state = S_NEXT;
            end
            S_NEXT: begin
                if (r_sp != '0)     n_state = S_POP;
                else if (r_p == r_k) n_state = S_RES;
                else                n_state = S_ROWSTART;
            end
            S_RES: begin
                row_ra  = r_cnt;
                n_state = S_RESW;
            end
            S_RESW: n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // stores
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && accept && load_ok) begin
            pt_mem[r_cnt[AW-1:0]] <= {i_pt.position, n_pw, n_pm};
        end
        r_pt_q <= pt_mem[pt_ra];
        if (r_state == S_WRITE) begin
            if (r_bank) row_b[r_mid] <= r_best;
            else        row_a[r_mid] <= r_best;
        end
        r_rowa_q <= row_a[row_ra];
        r_rowb_q <= row_b[row_ra];
        if (stk_we) stk_mem[stk_wa] <= stk_wd;
        r_stk_q <= stk_mem[sp_m1[SA_W-1:0]];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= PART_COUNT_RST;
            r_cnt       <= '0;
            r_fault     <= 1'b0;
            r_pw        <= '0;
            r_pm        <= '0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_k <= i_cfg_wdata;
            if (r_out_valid && o_res.ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept && load_ok) begin
                        if (r_cnt != '0 && i_pt.position < r_last_pos) r_fault <= 1'b1;
                        r_pw  <= n_pw;
                        r_pm  <= n_pm;
                        r_cnt <= r_cnt + IW'(1);
                    end
                end
                S_ROWSTART: r_sp <= SP_W'(1);
                S_POP:      r_sp <= sp_m1;
                S_PUSH1, S_PUSH2: begin
                    if (stk_we) r_sp <= r_sp + SP_W'(1);
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_cnt       <= '0;
                        r_fault     <= 1'b0;
                        r_pw        <= '0;
                        r_pm        <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept && load_ok) r_last_pos <= i_pt.position;
                r_p    <= CFG_W'(1);
                r_bank <= 1'b0;
            end
            S_START: r_feas <= feas_now;
            S_FRAME: begin
                r_lo   <= f_lo;
                r_hi   <= f_hi;
                r_olo  <= f_olo;
                r_ohi  <= f_ohi;
                r_mid  <= f_mid;
                r_q    <= f_olo;
                r_bo   <= f_olo;
                r_best <= ROW_UNREACHED;
            end
            S_TAILW: begin
                r_tpos <= pt_pos;
                r_tpw  <= pt_pw;
                r_tpm  <= pt_pm;
            end
            S_Q1: begin
                r_w <= r_tpw - ((r_q == '0) ? '0 : pt_pw);
                r_m <= r_tpm - ((r_q == '0) ? '0 : pt_pm);
                if (r_p == CFG_W'(1)) r_prev <= (r_q == '0) ? '0 : ROW_UNREACHED;
                else                  r_prev <= prev_q;
            end
            S_Q2: r_prod <= MW'(r_w * r_tpos);
            S_Q3: r_cost <= r_prod - r_m;
            S_Q4: begin
                if (cand < {1'b0, r_best}) begin
                    r_best <= cand[ROW_W-1:0];
                    r_bo   <= r_q;
                end
                r_q <= r_q + IW'(1);
            end
            S_NEXT: begin
                if (r_sp == '0 && r_p != r_k) begin
                    r_p    <= r_p + CFG_W'(1);
                    r_bank <= !r_bank;
                end
            end
            S_RESW: r_res <= r_bank ? r_rowb_q : r_rowa_q;
            S_DONE: begin
                if (out_free) begin
                    r_out_cost <= (r_feas && !r_fault) ? r_res[COST_W-1:0] : '0;
                    r_out_feas <= r_feas;
                    r_out_err  <= r_fault;
                end
            end
            default: ;
        endcase
    end

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_sp) <= STACK_DEPTH)
        else $error("stack pointer overflow");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= MAX_ITEMS)
        else $error("point count overflow");

    a_infeas_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (!r_out_feas || r_out_err)) |-> (r_out_cost == '0))
        else $error("nonzero cost on skipped search");

    a_new_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside done state");

endmodule
